/* rtl/core/wwc_pkg.sv */
package wwc_pkg;

	localparam int MAX_WORD_LEN = 16;
	localparam int COUNT_BITS   = 20;
	localparam int CFG_BITS     = 64;
	localparam int LEN_BITS     = $clog2(MAX_WORD_LEN + 1);
	localparam int IDX_BITS     = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
	localparam int REG_IDX_BITS = 2;

	localparam logic [REG_IDX_BITS-1:0] REG_WORD_LOW  = 2'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_WORD_HIGH = 2'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_WORD_LEN  = 2'd2;

	localparam logic [7:0] SPACE_BYTE      = 8'h20;
	localparam logic [7:0] UNDERSCORE_BYTE = 8'h5F;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef logic [MAX_WORD_LEN-1:0][7:0] byte_win_t;
	typedef logic [LEN_BITS-1:0]          len_t;
	typedef logic [COUNT_BITS-1:0]        count_t;

	// Outcome of comparing the byte window against the word.
	typedef struct packed {
		logic hit;
		logic delim_before;
	} match_t;

	// A byte is a delimiter unless it is a letter, a digit or an underscore.
	function automatic logic is_delim(input logic [7:0] b);
		logic word_char;
		word_char = ((b >= 8'h41) && (b <= 8'h5A)) ||
		            ((b >= 8'h61) && (b <= 8'h7A)) ||
		            ((b >= 8'h30) && (b <= 8'h39)) ||
		            (b == UNDERSCORE_BYTE);
		return !word_char;
	endfunction

	// Saturating increment of the running count.
	function automatic count_t sat_inc(input count_t c, input logic en);
		return (en && (c != COUNT_MAX)) ? count_t'(c + 1'b1) : c;
	endfunction

endpackage

/* rtl/core/wwc_if.sv */
interface wwc_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface wwc_count_if;
	logic        valid;
	logic        ready;
	logic [19:0] whole_word_count;

	modport source (output valid, output whole_word_count, input ready);
	modport sink   (input valid, input whole_word_count, output ready);
endinterface

interface wwc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  reg_index;
	logic [63:0] wr_data;

	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

/* rtl/core/wwc_match.sv */
module wwc_match (
	input  wwc_pkg::byte_win_t          new_win,
	input  wwc_pkg::byte_win_t          old_win,
	input  logic [2*wwc_pkg::CFG_BITS-1:0] word_bits,
	input  wwc_pkg::len_t               len,
	output wwc_pkg::match_t             result
);
	import wwc_pkg::*;

	byte_win_t     word;
	byte_win_t     target;
	logic [MAX_WORD_LEN-1:0] byte_ok;
	len_t          k;
	len_t          prev_idx;

	assign word = byte_win_t'(word_bits[MAX_WORD_LEN*8-1:0]);

	// The newest window byte lines up with the last word byte, so the word is
	// reversed around the configured length before the parallel compare.
	always_comb begin
		target  = '0;
		byte_ok = '0;
		k       = '0;
		for (int j = 0; j < MAX_WORD_LEN; j++) begin
			k = len_t'(len - len_t'(1) - len_t'(j));
			target[j] = word[k[IDX_BITS-1:0]];
			if (len_t'(j) < len) begin
				byte_ok[j] = (new_win[j] == target[j]);
			end else begin
				byte_ok[j] = 1'b1;
			end
		end
	end

	assign prev_idx = len_t'(len - len_t'(1));

	assign result.hit          = &byte_ok;
	assign result.delim_before = is_delim(old_win[prev_idx[IDX_BITS-1:0]]);

endmodule

/* rtl/core/whole_word_counter.sv */
// Whole-word counter.
//
// Text bytes arrive on the text channel, one item per byte, with end_of_text
// set on the final byte of each text. The block counts occurrences of the
// configured word that stand between delimiters (anything but letters,
// digits and underscore; the text edges also count). Matches never overlap.
// With the final byte one item carrying the saturating count leaves on the
// count channel, and the per-text state returns to its cleared form.
//
// The word and its length are written on the cfg channel, which is always
// ready. Write it only while no text is in flight.
//
// Throughput is one byte per cycle unless a final byte waits for the output register:
// the whole window compare is combinational between the state registers and the
// output register. A count appears on the output in the cycle after its final byte
// is accepted. When the receiver stalls, the output register holds the count and
// the text channel keeps taking bytes until a second final byte would need that
// register. Reset (arst_n low) clears the window to spaces, zeroes the count and
// the skip state, sets the word length to one and empties the output register.
module whole_word_counter (
	input  logic          clk,
	input  logic          arst_n,
	wwc_cfg_if.sink       cfg,
	wwc_text_if.sink      text,
	wwc_count_if.source   count
);
	import wwc_pkg::*;

	logic [CFG_BITS-1:0] word_low_q;
	logic [CFG_BITS-1:0] word_high_q;
	logic [4:0]          word_len_q;

	byte_win_t win_q;
	len_t      seen_q;
	len_t      skip_q;
	logic      pending_q;
	count_t    total_q;

	logic      out_valid_q;
	count_t    out_count_q;

	len_t      len;
	byte_win_t new_win;
	len_t      seen_new;
	match_t    m;
	logic      accept;
	logic      last;
	logic      bump_pending;
	logic      bump_now;
	logic      try_match;
	count_t    total_a;
	count_t    total_b;
	len_t      skip_new;

	// Configuration is never back-pressured.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_low_q  <= '0;
			word_high_q <= '0;
			word_len_q  <= 5'd1;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				REG_WORD_LOW:  word_low_q  <= cfg.wr_data;
				REG_WORD_HIGH: word_high_q <= cfg.wr_data;
				REG_WORD_LEN:  word_len_q  <= cfg.wr_data[4:0];
				default: ;
			endcase
		end
	end

	// A length of zero acts as one, anything past the maximum as the maximum.
	always_comb begin
		if (word_len_q == 5'd0) begin
			len = len_t'(1);
		end else if (LEN_BITS'(word_len_q) > len_t'(MAX_WORD_LEN) ||
		             word_len_q > 5'(MAX_WORD_LEN)) begin
			len = len_t'(MAX_WORD_LEN);
		end else begin
			len = len_t'(word_len_q);
		end
	end

	// Only a final byte needs the output register. It may enter when the
	// register is empty or being drained; other bytes never wait for it.
	assign text.ready = !out_valid_q || count.ready || !text.end_of_text;
	assign accept     = text.valid && text.ready;
	assign last       = text.end_of_text;

	// Window after shifting in the new byte, newest byte at index zero.
	always_comb begin
		new_win[0] = text.text_byte;
		for (int j = 1; j < MAX_WORD_LEN; j++) begin
			new_win[j] = win_q[j-1];
		end
	end

	assign seen_new = (seen_q == len_t'(MAX_WORD_LEN)) ? seen_q : len_t'(seen_q + 1'b1);

	wwc_match u_match (
		.new_win   (new_win),
		.old_win   (win_q),
		.word_bits ({word_high_q, word_low_q}),
		.len       (len),
		.result    (m)
	);

	// A match whose preceding byte was a delimiter counts once the following
	// byte turns out to be a delimiter too; the end of the text also serves.
	assign bump_pending = pending_q && is_delim(text.text_byte);
	assign try_match    = (skip_q == '0) && (seen_new >= len) && m.hit;
	assign bump_now     = try_match && m.delim_before && last;
	assign total_a      = sat_inc(total_q, bump_pending);
	assign total_b      = sat_inc(total_a, bump_now);

	always_comb begin
		if (skip_q != '0) begin
			skip_new = len_t'(skip_q - 1'b1);
		end else if (try_match) begin
			skip_new = len_t'(len - 1'b1);
		end else begin
			skip_new = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_WORD_LEN; j++) begin
				win_q[j] <= SPACE_BYTE;
			end
			seen_q    <= '0;
			skip_q    <= '0;
			pending_q <= 1'b0;
			total_q   <= '0;
		end else if (accept) begin
			if (last) begin
				for (int j = 0; j < MAX_WORD_LEN; j++) begin
					win_q[j] <= SPACE_BYTE;
				end
				seen_q    <= '0;
				skip_q    <= '0;
				pending_q <= 1'b0;
				total_q   <= '0;
			end else begin
				win_q     <= new_win;
				seen_q    <= seen_new;
				skip_q    <= skip_new;
				pending_q <= try_match && m.delim_before;
				total_q   <= total_b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && last) begin
			out_valid_q <= 1'b1;
		end else if (count.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last) begin
			out_count_q <= total_b;
		end
	end

	assign count.valid            = out_valid_q;
	assign count.whole_word_count = out_count_q;

endmodule
